// File: rtl/core/c_subset_token_lexer_defines.svh
// Assertion macros shared by the lexer modules.
`ifndef C_SUBSET_TOKEN_LEXER_DEFINES_SVH
`define C_SUBSET_TOKEN_LEXER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLEX_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CLEX_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/clex_pkg.sv
package clex_pkg;

  // Lexer modes held between source bytes.
  typedef enum logic [3:0] {
    LM_IDLE     = 4'd0,
    LM_WORD     = 4'd1,
    LM_OPER     = 4'd2,
    LM_CHR      = 4'd3,
    LM_STR      = 4'd4,
    LM_SLASH    = 4'd5,
    LM_CMT      = 4'd6,
    LM_CMT_STAR = 4'd7
  } lex_mode_e;

  // Token kinds carried with every result.
  typedef enum logic [2:0] {
    TK_WORD   = 3'd0,
    TK_OPER   = 3'd1,
    TK_CHR    = 3'd2,
    TK_STR    = 3'd3,
    TK_SINGLE = 3'd4,
    TK_EOI    = 3'd5,
    TK_ERR    = 3'd6
  } tok_kind_e;

  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_DQUOTE = 8'd34;
  localparam logic [7:0] CH_QUOTE  = 8'd39;
  localparam logic [7:0] CH_STAR   = 8'd42;
  localparam logic [7:0] CH_SLASH  = 8'd47;
  localparam logic [7:0] CH_UNDER  = 8'd95;

  // One source byte as it arrives.
  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } clex_in_t;

  // One result as it leaves.
  typedef struct packed {
    logic [7:0] token_byte;
    logic       has_byte;
    logic       token_start;
    logic       token_end;
    tok_kind_e  token_kind;
    logic       last;
  } clex_out_t;

  // Everything one source byte causes: one or two results.
  typedef struct packed {
    logic      two;
    clex_out_t first;
    clex_out_t second;
  } clex_bundle_t;

  // Outcome of lexing a byte as though no token were open.
  typedef struct packed {
    logic      put;
    clex_out_t rec;
    lex_mode_e mode;
  } idle_step_t;

  function automatic clex_out_t mk_rec(logic [7:0] b, logic has, logic st, logic en,
                                       tok_kind_e kind);
    clex_out_t r;
    r.token_byte  = b;
    r.has_byte    = has;
    r.token_start = st;
    r.token_end   = en;
    r.token_kind  = kind;
    r.last        = 1'b0;
    return r;
  endfunction

  function automatic logic is_word(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "0" && c <= "9") || (c == CH_UNDER);
  endfunction

  function automatic logic is_oper(logic [7:0] c);
    return (c == "<") || (c == "=") || (c == ">") || (c == "|") || (c == "&") ||
           (c == "!");
  endfunction

  function automatic idle_step_t idle_step(logic [7:0] c);
    idle_step_t s;
    s.put  = 1'b1;
    s.rec  = mk_rec(c, 1'b1, 1'b1, 1'b0, TK_WORD);
    s.mode = LM_IDLE;
    if (c == CH_SPACE || c == CH_TAB || c == CH_LF) begin
      s.put = 1'b0;
    end else if (is_word(c)) begin
      s.mode = LM_WORD;
    end else if (is_oper(c)) begin
      s.rec.token_kind = TK_OPER;
      s.mode = LM_OPER;
    end else if (c == CH_QUOTE) begin
      s.rec.token_kind = TK_CHR;
      s.mode = LM_CHR;
    end else if (c == CH_DQUOTE) begin
      s.rec.token_kind = TK_STR;
      s.mode = LM_STR;
    end else if (c == CH_SLASH) begin
      s.put  = 1'b0;
      s.mode = LM_SLASH;
    end else begin
      s.rec.token_kind = TK_SINGLE;
      s.rec.token_end  = 1'b1;
    end
    return s;
  endfunction

endpackage

// File: rtl/core/clex_front.sv
`include "c_subset_token_lexer_defines.svh"

module clex_front
  import clex_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  clex_in_t     in_data_i,
  input  logic         q_full_i,
  output logic         push_o,
  output clex_bundle_t bundle_o
);

  lex_mode_e  mode_q, mode_d;
  logic       accept;
  logic [7:0] c;
  logic       eoi;
  logic [1:0] n;
  clex_out_t  r0, r1;
  idle_step_t is;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign c          = in_data_i.char_code;
  assign eoi        = in_data_i.end_of_input;
  assign is         = idle_step(c);

  // Mode register, advanced on every input transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= LM_IDLE;
    end else if (accept) begin
      mode_q <= mode_d;
    end
  end

  // Classify the byte against the current mode and form its results.
  always_comb begin
    n      = 2'd0;
    r0     = mk_rec(8'd0, 1'b0, 1'b0, 1'b0, TK_WORD);
    r1     = mk_rec(8'd0, 1'b0, 1'b1, 1'b1, TK_EOI);
    mode_d = mode_q;
    if (eoi) begin
      mode_d = LM_IDLE;
      unique case (mode_q)
        LM_WORD, LM_OPER: begin
          r0 = mk_rec(8'd0, 1'b0, 1'b0, 1'b1, (mode_q == LM_WORD) ? TK_WORD : TK_OPER);
          n  = 2'd2;
        end
        LM_SLASH: begin
          r0 = mk_rec(CH_SLASH, 1'b1, 1'b1, 1'b1, TK_SINGLE);
          n  = 2'd2;
        end
        LM_CHR, LM_STR: begin
          r0 = mk_rec(8'd0, 1'b0, 1'b0, 1'b1, TK_ERR);
          n  = 2'd1;
        end
        LM_CMT, LM_CMT_STAR: begin
          r0 = mk_rec(8'd0, 1'b0, 1'b1, 1'b1, TK_ERR);
          n  = 2'd1;
        end
        default: begin
          r0 = mk_rec(8'd0, 1'b0, 1'b1, 1'b1, TK_EOI);
          n  = 2'd1;
        end
      endcase
    end else begin
      unique case (mode_q)
        LM_WORD, LM_OPER: begin
          if ((mode_q == LM_WORD) ? is_word(c) : is_oper(c)) begin
            r0 = mk_rec(c, 1'b1, 1'b0, 1'b0, (mode_q == LM_WORD) ? TK_WORD : TK_OPER);
            n  = 2'd1;
          end else begin
            r0     = mk_rec(8'd0, 1'b0, 1'b0, 1'b1,
                            (mode_q == LM_WORD) ? TK_WORD : TK_OPER);
            r1     = is.rec;
            n      = is.put ? 2'd2 : 2'd1;
            mode_d = is.mode;
          end
        end
        LM_CHR: begin
          r0 = mk_rec(c, 1'b1, 1'b0, c == CH_QUOTE, TK_CHR);
          n  = 2'd1;
          if (c == CH_QUOTE) begin
            mode_d = LM_IDLE;
          end
        end
        LM_STR: begin
          r0 = mk_rec(c, 1'b1, 1'b0, c == CH_DQUOTE, TK_STR);
          n  = 2'd1;
          if (c == CH_DQUOTE) begin
            mode_d = LM_IDLE;
          end
        end
        LM_SLASH: begin
          if (c == CH_STAR) begin
            mode_d = LM_CMT_STAR;
          end else begin
            r0     = mk_rec(CH_SLASH, 1'b1, 1'b1, 1'b1, TK_SINGLE);
            r1     = is.rec;
            n      = is.put ? 2'd2 : 2'd1;
            mode_d = is.mode;
          end
        end
        LM_CMT: begin
          if (c == CH_STAR) begin
            mode_d = LM_CMT_STAR;
          end
        end
        LM_CMT_STAR: begin
          if (c == CH_SLASH) begin
            mode_d = LM_IDLE;
          end else if (c != CH_STAR) begin
            mode_d = LM_CMT;
          end
        end
        default: begin
          r0     = is.rec;
          n      = is.put ? 2'd1 : 2'd0;
          mode_d = is.mode;
        end
      endcase
    end
  end

  // Bundle the results; the final one of the pair carries the last mark.
  always_comb begin
    bundle_o             = '0;
    bundle_o.two         = (n == 2'd2);
    bundle_o.first       = r0;
    bundle_o.first.last  = (n != 2'd2);
    bundle_o.second      = r1;
    bundle_o.second.last = 1'b1;
  end

  assign push_o = accept && (n != 2'd0);

  // A byte inside a comment never produces a result.
  `CLEX_ASSERT_IMPL(a_cmt_silent, clk_i, rst_ni,
    accept && !eoi && (mode_q == LM_CMT || mode_q == LM_CMT_STAR), !push_o,
    "comment byte produced a result")

endmodule

// File: rtl/core/clex_fifo.sv
`include "c_subset_token_lexer_defines.svh"

module clex_fifo
  import clex_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  clex_bundle_t wdata_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output clex_bundle_t rdata_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  clex_bundle_t            mem_q [DEPTH];
  logic         [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic         [CntW-1:0] count_q;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Storage for queued bundles.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `CLEX_ASSERT_IMPL(a_pop_nonempty, clk_i, rst_ni, pop_i, count_q != '0,
    "pop from an empty queue")
  `CLEX_ASSERT_NEXT(a_fill_up, clk_i, rst_ni, push_i && !pop_i,
    count_q == $past(count_q) + 1'b1, "queue level did not rise on a lone push")

endmodule

// File: rtl/core/clex_back.sv
`include "c_subset_token_lexer_defines.svh"

module clex_back
  import clex_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         q_valid_i,
  input  clex_bundle_t q_data_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output clex_out_t    out_data_o
);

  clex_out_t out_q, sec_q;
  logic      out_valid_q, sec_valid_q;
  logic      load;

  // The output register may take a new result when empty or being drained.
  assign load  = !out_valid_q || out_ready_i;
  assign pop_o = load && !sec_valid_q && q_valid_i;

  // Control: which result sits in the output register, and whether a
  // second one of the same byte still waits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sec_valid_q <= 1'b0;
    end else if (load) begin
      if (sec_valid_q) begin
        out_valid_q <= 1'b1;
        sec_valid_q <= 1'b0;
      end else begin
        out_valid_q <= q_valid_i;
        sec_valid_q <= q_valid_i && q_data_i.two;
      end
    end
  end

  // Result payloads.
  always_ff @(posedge clk_i) begin
    if (load) begin
      if (sec_valid_q) begin
        out_q <= sec_q;
      end else if (q_valid_i) begin
        out_q <= q_data_i.first;
        sec_q <= q_data_i.second;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A shown result without the last mark always has its partner waiting.
  `CLEX_ASSERT_IMPL(a_pair_held, clk_i, rst_ni, out_valid_q && !out_q.last, sec_valid_q,
    "first of a pair shown without its second")

endmodule

// File: rtl/core/c_subset_token_lexer.sv
// Streaming lexer for a small C subset.
// Input channel (in_valid_i/in_ready_o/in_data_i): one source byte per
// transfer, or an end-of-input marker when end_of_input is set.
// Output channel (out_valid_o/out_ready_i/out_data_o): token bytes and pure
// markers with start, end and kind flags; the last result a byte causes has
// last set. A byte causes zero, one or two results.
// The front end classifies a byte in the cycle it is transferred and queues
// its results; the back end drains the queue through an output register.
// The first result passes through the queue and then the output register
// before it is shown, and it transfers once the receiver is ready.
// Input is taken at one byte per cycle while the queue has room; output
// runs at one result per cycle while the receiver is ready, so the extra
// result of a two-result byte is absorbed by the QUEUE_DEPTH-entry queue.
// When the receiver stalls, results collect in the queue and in_ready_o
// falls once it is full. Reset empties the queue and returns the lexer to
// its idle mode between tokens; no clearing pass is needed.
module c_subset_token_lexer
  import clex_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  clex_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output clex_out_t out_data_o
);

  logic         q_full, q_push, q_pop, q_valid;
  clex_bundle_t q_wdata, q_rdata;

  clex_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .bundle_o   (q_wdata)
  );

  clex_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  clex_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_rdata),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import clex_pkg::*;

  localparam int unsigned LONG_STALL = 120;
  localparam int unsigned TAIL_CYCLES = 16;
  localparam logic [8:0] END_MARK = 9'h100;

  // Collects expected token results and checks the stream leaving the lexer.
  class lexer_scoreboard;
    lex_mode_e   mode;
    clex_out_t   expected_q[$];
    clex_out_t   step_q[$];
    int unsigned n_errors;
    int unsigned n_bytes;
    int unsigned n_results;
    int unsigned kind_count[7];

    function new();
      mode = LM_IDLE;
    endfunction

    function automatic logic word_char(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "0" && c <= "9") || c == CH_UNDER;
    endfunction

    function automatic logic oper_char(logic [7:0] c);
      return c == "<" || c == "=" || c == ">" || c == "|" || c == "&" || c == "!";
    endfunction

    function void emit(logic [7:0] b, logic has, logic st, logic en, tok_kind_e kind);
      clex_out_t r;
      r.token_byte  = b;
      r.has_byte    = has;
      r.token_start = st;
      r.token_end   = en;
      r.token_kind  = kind;
      r.last        = 1'b0;
      step_q.push_back(r);
    endfunction

    // A byte seen with no token open.
    function void open_token(logic [7:0] c);
      mode = LM_IDLE;
      if (c == CH_SPACE || c == CH_TAB || c == CH_LF) begin
        mode = LM_IDLE;
      end else if (word_char(c)) begin
        emit(c, 1'b1, 1'b1, 1'b0, TK_WORD);
        mode = LM_WORD;
      end else if (oper_char(c)) begin
        emit(c, 1'b1, 1'b1, 1'b0, TK_OPER);
        mode = LM_OPER;
      end else if (c == CH_QUOTE) begin
        emit(c, 1'b1, 1'b1, 1'b0, TK_CHR);
        mode = LM_CHR;
      end else if (c == CH_DQUOTE) begin
        emit(c, 1'b1, 1'b1, 1'b0, TK_STR);
        mode = LM_STR;
      end else if (c == CH_SLASH) begin
        mode = LM_SLASH;
      end else begin
        emit(c, 1'b1, 1'b1, 1'b1, TK_SINGLE);
      end
    endfunction

    // Works out the results that one accepted source byte causes.
    function void note_byte(clex_in_t item);
      clex_out_t r;
      logic [7:0] c;
      c = item.char_code;
      step_q.delete();
      n_bytes++;
      if (item.end_of_input) begin
        case (mode)
          LM_WORD: begin
            emit(8'd0, 1'b0, 1'b0, 1'b1, TK_WORD);
            emit(8'd0, 1'b0, 1'b1, 1'b1, TK_EOI);
          end
          LM_OPER: begin
            emit(8'd0, 1'b0, 1'b0, 1'b1, TK_OPER);
            emit(8'd0, 1'b0, 1'b1, 1'b1, TK_EOI);
          end
          LM_SLASH: begin
            emit(CH_SLASH, 1'b1, 1'b1, 1'b1, TK_SINGLE);
            emit(8'd0, 1'b0, 1'b1, 1'b1, TK_EOI);
          end
          LM_CHR, LM_STR: emit(8'd0, 1'b0, 1'b0, 1'b1, TK_ERR);
          LM_CMT, LM_CMT_STAR: emit(8'd0, 1'b0, 1'b1, 1'b1, TK_ERR);
          default: emit(8'd0, 1'b0, 1'b1, 1'b1, TK_EOI);
        endcase
        mode = LM_IDLE;
      end else begin
        case (mode)
          LM_WORD: begin
            if (word_char(c)) begin
              emit(c, 1'b1, 1'b0, 1'b0, TK_WORD);
            end else begin
              emit(8'd0, 1'b0, 1'b0, 1'b1, TK_WORD);
              open_token(c);
            end
          end
          LM_OPER: begin
            if (oper_char(c)) begin
              emit(c, 1'b1, 1'b0, 1'b0, TK_OPER);
            end else begin
              emit(8'd0, 1'b0, 1'b0, 1'b1, TK_OPER);
              open_token(c);
            end
          end
          LM_CHR: begin
            emit(c, 1'b1, 1'b0, c == CH_QUOTE, TK_CHR);
            if (c == CH_QUOTE) mode = LM_IDLE;
          end
          LM_STR: begin
            emit(c, 1'b1, 1'b0, c == CH_DQUOTE, TK_STR);
            if (c == CH_DQUOTE) mode = LM_IDLE;
          end
          LM_SLASH: begin
            if (c == CH_STAR) begin
              mode = LM_CMT_STAR;
            end else begin
              emit(CH_SLASH, 1'b1, 1'b1, 1'b1, TK_SINGLE);
              open_token(c);
            end
          end
          LM_CMT: begin
            if (c == CH_STAR) mode = LM_CMT_STAR;
          end
          LM_CMT_STAR: begin
            if (c == CH_SLASH) begin
              mode = LM_IDLE;
            end else if (c != CH_STAR) begin
              mode = LM_CMT;
            end
          end
          default: open_token(c);
        endcase
      end
      // The final result of this byte carries the last flag.
      foreach (step_q[i]) begin
        r = step_q[i];
        r.last = (i == step_q.size() - 1);
        expected_q.push_back(r);
      end
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, got);
        n_errors++;
      end
    endfunction

    // Checks one result transfer against the oldest expectation.
    function void check_result(clex_out_t got);
      clex_out_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected: expected none, actual byte 0x%0h kind %0d",
                 $time, got.token_byte, got.token_kind);
        n_errors++;
        return;
      end
      want = expected_q.pop_front();
      n_results++;
      kind_count[want.token_kind]++;
      compare_field("token_byte", want.token_byte, got.token_byte);
      compare_field("has_byte", want.has_byte, got.has_byte);
      compare_field("token_start", want.token_start, got.token_start);
      compare_field("token_end", want.token_end, got.token_end);
      compare_field("token_kind", want.token_kind, got.token_kind);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  clex_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  clex_out_t out_data_o;

  lexer_scoreboard sb;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned stall_asked;
  int unsigned stall_given;
  int unsigned stall_left;
  int unsigned n_items;
  string       word_chars  = "abcdefghijklmnopqrstuvwxyz0123456789_";
  string       oper_chars  = "<=>|&!";
  string       single_chars = "ABMZ(){}[];,+-*%.#?:~^@$";
  string       comment_chars = "***//ab \n";

  // Directed opening: field extremes and corners of the token rules.
  logic [8:0] opening_seq [$] = '{
    {1'b0, "a"}, {1'b0, CH_UNDER}, {1'b0, "9"},   // word
    {1'b0, "="},                                  // ends word, opens operator
    {1'b0, CH_TAB},                               // ends operator, separator
    9'h000, 9'h0FF,                               // one-byte tokens at extremes
    {1'b0, CH_SLASH}, {1'b0, "x"},                // held slash before a word
    {1'b1, 8'hA5},                                // end of input inside a word
    {1'b0, CH_SLASH}, {1'b1, 8'h5A},              // end of input on a held slash
    {1'b0, CH_QUOTE}, {1'b0, "q"}, {1'b0, CH_QUOTE},
    {1'b0, CH_DQUOTE}, END_MARK,                  // unterminated string
    {1'b0, CH_SLASH}, {1'b0, CH_STAR}, {1'b0, CH_SLASH},
    {1'b0, CH_SLASH}, {1'b0, CH_STAR}, END_MARK,  // unterminated comment
    {1'b0, "<"}, END_MARK,                        // end of input inside an operator
    END_MARK                                      // end of input between tokens
  };

  c_subset_token_lexer i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Receiver: random back-pressure, or a long hold-off when one is requested.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (stall_asked != stall_given) begin
      out_ready_i <= 1'b0;
      stall_left  <= LONG_STALL - 1;
      stall_given <= stall_given + 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Every result transfer is checked against the prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(out_data_o);
    end
  end

  initial begin
    #5ms;
    $display("Timeout with %0d results still outstanding.", sb.expected_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [7:0] pick(string set);
    return set[$urandom_range(set.len() - 1)];
  endfunction

  // Offers one source byte and waits for its transfer.
  task automatic send_item(logic [7:0] c, logic eoi);
    clex_in_t d;
    d.char_code    = c;
    d.end_of_input = eoi;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_byte(d);
    if (eoi || !(c == CH_SPACE || c == CH_TAB || c == CH_LF)) n_items++;
  endtask

  task automatic send_char(logic [7:0] c);
    send_item(c, 1'b0);
  endtask

  task automatic send_end();
    send_item(8'($urandom_range(255)), 1'b1);
  endtask

  // Body bytes never contain the closer (the closing quote, or a comment's star).
  task automatic send_literal_body(logic [7:0] closer, int unsigned len);
    logic [7:0] b;
    repeat (len) begin
      do b = 8'($urandom_range(255)); while (b == closer);
      send_char(b);
    end
  endtask

  // Sender stops offering and waits until every expected result has arrived.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.expected_q.size() != 0);
  endtask

  // Mostly well-formed tokens with random content; the rest is noise and
  // sequences cut short by end of input.
  task automatic send_random_token();
    int unsigned sel;
    logic [7:0] opener;
    sel = $urandom_range(99);
    if (sel < 22) begin
      repeat ($urandom_range(6, 1)) send_char(pick(word_chars));
    end else if (sel < 33) begin
      repeat ($urandom_range(3, 1)) send_char(pick(oper_chars));
    end else if (sel < 40) begin
      send_char(CH_QUOTE);
      send_literal_body(CH_QUOTE, $urandom_range(2));
      send_char(CH_QUOTE);
    end else if (sel < 48) begin
      send_char(CH_DQUOTE);
      send_literal_body(CH_DQUOTE, $urandom_range(5));
      send_char(CH_DQUOTE);
    end else if (sel < 56) begin
      send_char(CH_SLASH);
      send_char(CH_STAR);
      if ($urandom_range(3) != 0) begin
        repeat ($urandom_range(6)) begin
          if ($urandom_range(1) != 0) send_char(pick(comment_chars));
          else send_char(8'($urandom_range(255)));
        end
        send_char(CH_STAR);
      end
      send_char(CH_SLASH);
    end else if (sel < 62) begin
      send_char(CH_SLASH);
    end else if (sel < 70) begin
      send_char(pick(" \t\n"));
    end else if (sel < 78) begin
      if ($urandom_range(1) != 0) send_char(pick(single_chars));
      else send_char(8'($urandom_range(255, 128)));
    end else if (sel < 81) begin
      send_end();
    end else if (sel < 85) begin
      case ($urandom_range(2))
        0: opener = CH_QUOTE;
        1: opener = CH_DQUOTE;
        default: opener = CH_SLASH;
      endcase
      send_char(opener);
      if (opener == CH_SLASH) send_char(CH_STAR);
      send_literal_body(opener == CH_SLASH ? CH_STAR : opener, $urandom_range(3));
      send_end();
    end else begin
      send_char(8'($urandom_range(255)));
    end
  endtask

  initial begin
    sb            = new();
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    out_ready_i   = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_asked   = 0;
    stall_given   = 0;
    stall_left    = 0;
    n_items       = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening with light idling on both sides.
    send_idle_pct = 10;
    recv_idle_pct <= 10;
    foreach (opening_seq[i]) send_item(opening_seq[i][7:0], opening_seq[i][8]);
    drain();

    // Sender idles lightly, receiver heavily.
    send_idle_pct = 22;
    recv_idle_pct <= 63;
    while (n_items < 480) send_random_token();
    drain();

    // Sender idles heavily, receiver lightly.
    send_idle_pct = 63;
    recv_idle_pct <= 22;
    while (n_items < 940) send_random_token();
    drain();

    // No idling; a long receiver hold-off fills the block while bytes keep coming.
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    while (n_items < 1100) send_random_token();
    stall_asked <= stall_asked + 1;
    while (n_items < 1400) send_random_token();
    drain();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Lexed %0d source bytes (%0d from the directed opening) into %0d checked results.",
             sb.n_bytes, opening_seq.size(), sb.n_results);
    $display("Results by kind: word %0d, operator %0d, char %0d, string %0d, single %0d, end %0d, unterminated %0d.",
             sb.kind_count[TK_WORD], sb.kind_count[TK_OPER], sb.kind_count[TK_CHR],
             sb.kind_count[TK_STR], sb.kind_count[TK_SINGLE], sb.kind_count[TK_EOI],
             sb.kind_count[TK_ERR]);
    if (sb.n_errors == 0 && sb.expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
